// File: src/assert_macros.svh
// Assertion macros shared by the statistics counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CCSC_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ccsc check failed");

// Next-cycle implication, checked outside reset
`define CCSC_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ccsc next-cycle check failed");

`endif

// File: src/ccsc_pkg.sv
// Types, codes and counter layout constants of the credit control statistics counter.
package ccsc_pkg;

    typedef logic [63:0] t_word;
    typedef logic [1:0]  t_status;

    // Result status codes
    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_IGNORED = 2'd1;
    localparam t_status ST_SKIPPED = 2'd2;

    // Operation codes
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Access type and request kind codes
    localparam logic [1:0] ACC_UNKNOWN    = 2'd3;
    localparam logic [1:0] KIND_TERMINATE = 2'd2;
    localparam logic [1:0] KIND_OTHER     = 2'd3;

    localparam int ACCESS_KINDS   = 3;
    localparam int CAUSE_BINS     = 10;
    localparam int ABANDON_REASON = 6;

    // Counter layout inside one set
    localparam int IX_MSG         = 0;
    localparam int IX_INIT        = 1;
    localparam int IX_OCT_IN      = 4;
    localparam int IX_OCT_OUT     = 5;
    localparam int FIXED_COUNTERS = 6;

    // Field widths
    localparam int BKT_W    = 13;
    localparam int OFF_W    = 6;
    localparam int WIDE_W   = 30;

    // Update slots of one item, lowest goes first
    localparam int NUM_SLOTS = 7;
    typedef logic [2:0]           t_slot;
    typedef logic [NUM_SLOTS-1:0] t_slot_mask;

    localparam t_slot SLOT_OCT_IN  = 3'd0;
    localparam t_slot SLOT_OCT_OUT = 3'd1;
    localparam t_slot SLOT_REASON  = 3'd2;
    localparam t_slot SLOT_MSG     = 3'd3;
    localparam t_slot SLOT_KIND    = 3'd4;
    localparam t_slot SLOT_CAUSE   = 3'd5;
    localparam t_slot SLOT_READ    = 3'd6;

    // Lowest pending slot
    function automatic t_slot first_slot(input t_slot_mask mask);
        t_slot sel;
        sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                sel = t_slot'(i);
            end
        end
        return sel;
    endfunction

endpackage

// File: src/ccsc_ram.sv
// Counter memory: one write port and one registered read port.
module ccsc_ram #(
    parameter int DEPTH = 638976,
    parameter int AW    = 20
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  ccsc_pkg::t_word i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output ccsc_pkg::t_word o_rdata
);
    import ccsc_pkg::*;

    t_word mem [DEPTH];
    t_word r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/credit_control_stats_counter.sv
// A word that touches no counter goes from decode to output; else it passes address and run for n = 1..6 updates.
// A bucket at or past TIME_BUCKETS first passes the wrap state for the reciprocal-multiply reduction.
// One word at a time: each counter update is a read then a write-back on the counter memory.
// A new word is taken while the previous result still waits in the output register.
// Reset clears the memory, one entry a cycle, over all TIME_BUCKETS*3*(16+REASON_BINS) entries
// (638976 by default); no word is accepted during that pass.
`include "assert_macros.svh"

module credit_control_stats_counter #(
    parameter int TIME_BUCKETS = 8192,
    parameter int REASON_BINS  = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [12:0]           i_bucket,
    input  logic [1:0]            i_access_type,
    input  logic [1:0]            i_request_kind,
    input  logic signed [5:0]     i_term_cause,
    input  logic                  i_has_unit,
    input  logic [31:0]           i_octets_in,
    input  logic [31:0]           i_octets_out,
    input  logic signed [5:0]     i_report_reason,
    input  logic                  i_last_unit,
    input  logic [4:0]            i_counter_index,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ccsc_pkg::t_status     o_status,
    output ccsc_pkg::t_word       o_read_value
);
    import ccsc_pkg::*;

    localparam int CPS   = FIXED_COUNTERS + REASON_BINS + CAUSE_BINS;
    localparam int DEPTH = TIME_BUCKETS * ACCESS_KINDS * CPS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = (TIME_BUCKETS > 1) ? $clog2(TIME_BUCKETS) : 1;

    localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [WIDE_W-1:0] TB_WIDE   = WIDE_W'(TIME_BUCKETS);

    // Reciprocal of TIME_BUCKETS, exact quotient for any 13-bit bucket
    localparam int                WRAP_SHIFT = BKT_W + $clog2(TIME_BUCKETS);
    localparam logic [WIDE_W-1:0] WRAP_RECIP =
        WIDE_W'(((1 << WRAP_SHIFT) + TIME_BUCKETS - 1) / TIME_BUCKETS);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_WRAP  = 3'd3;
    localparam logic [2:0] S_ADDR  = 3'd4;
    localparam logic [2:0] S_RUN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]        r_state;
    logic [AW-1:0]     r_clr_addr;
    logic              r_aband;

    // captured word
    logic              r_op;
    logic [BKT_W-1:0]  r_bucket;
    logic [1:0]        r_access;
    logic [1:0]        r_kind;
    logic [5:0]        r_cause;
    logic              r_has_unit;
    logic [31:0]       r_oin;
    logic [31:0]       r_oout;
    logic [5:0]        r_reason;
    logic              r_last;
    logic [4:0]        r_idx;

    // work registers
    t_slot_mask        r_mask;
    t_status           r_status;
    t_word             r_value;
    logic [BKT_W-1:0]  r_quot;
    logic              r_wphase;
    logic [BW-1:0]     r_bidx;
    logic [AW-1:0]     r_base;
    logic              r_pend_valid;
    t_slot             r_pend_slot;
    logic [AW-1:0]     r_pend_addr;

    // output register
    logic              r_out_valid;
    t_status           r_out_status;
    t_word             r_out_value;

    // memory port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_word             ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    t_word             ram_rdata;

    logic              in_acc;
    logic              ends;
    logic              reason_six;
    logic              reason_binned;
    logic              cause_binned;
    logic              bucket_ok;
    t_slot_mask        n_mask;
    t_status           n_status;
    logic              n_aband;
    logic              n_needs_ram;
    logic [WIDE_W-1:0] wrap_prod;
    logic [WIDE_W-1:0] wrap_back;
    logic [WIDE_W-1:0] wrap_rem;
    t_slot             pick;
    logic [OFF_W-1:0]  pick_off;
    logic [31:0]       pend_add;
    logic              out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_value;

    // Decode of the captured word
    assign ends          = r_last || !r_has_unit;
    assign reason_six    = (r_reason == 6'(ABANDON_REASON));
    assign reason_binned = !r_reason[5] && (r_reason[4:0] < 5'(REASON_BINS));
    assign cause_binned  = !r_cause[5] && (r_cause[4:0] < 5'(CAUSE_BINS));
    assign bucket_ok     = WIDE_W'(r_bucket) < TB_WIDE;

    always_comb begin
        n_mask      = '0;
        n_status    = ST_DONE;
        n_aband     = r_aband;
        n_needs_ram = 1'b0;
        if (r_op == OP_READ) begin
            if (r_access == ACC_UNKNOWN) begin
                n_status = ST_IGNORED;
            end else if (OFF_W'(r_idx) < OFF_W'(CPS)) begin
                n_mask[SLOT_READ] = 1'b1;
                n_needs_ram       = 1'b1;
            end
        end else if (r_aband) begin
            n_status = ST_SKIPPED;
            if (ends) begin
                n_aband = 1'b0;
            end
        end else if (r_access == ACC_UNKNOWN) begin
            n_status = ST_IGNORED;
        end else begin
            n_needs_ram = 1'b1;
            if (r_has_unit) begin
                n_mask[SLOT_OCT_IN]  = 1'b1;
                n_mask[SLOT_OCT_OUT] = 1'b1;
                if (reason_six) begin
                    n_status = ST_SKIPPED;
                    n_aband  = !ends;
                end else begin
                    n_mask[SLOT_REASON] = reason_binned;
                end
            end
            if (ends && !(r_has_unit && reason_six)) begin
                n_mask[SLOT_MSG]   = 1'b1;
                n_mask[SLOT_KIND]  = (r_kind != KIND_OTHER);
                n_mask[SLOT_CAUSE] = (r_kind == KIND_TERMINATE) && cause_binned;
            end
        end
    end

    // Bucket reduction: quotient by reciprocal multiply, then remainder
    assign wrap_prod = WIDE_W'(r_bucket) * WRAP_RECIP;
    assign wrap_back = WIDE_W'(r_quot) * TB_WIDE;
    assign wrap_rem  = WIDE_W'(r_bucket) - wrap_back;

    // Counter offset of the next slot to issue
    assign pick = first_slot(r_mask);
    always_comb begin
        unique case (pick)
            SLOT_OCT_IN:  pick_off = OFF_W'(IX_OCT_IN);
            SLOT_OCT_OUT: pick_off = OFF_W'(IX_OCT_OUT);
            SLOT_REASON:  pick_off = OFF_W'(FIXED_COUNTERS) + OFF_W'(r_reason[3:0]);
            SLOT_MSG:     pick_off = OFF_W'(IX_MSG);
            SLOT_KIND:    pick_off = OFF_W'(IX_INIT) + OFF_W'(r_kind);
            SLOT_CAUSE:   pick_off = OFF_W'(FIXED_COUNTERS + REASON_BINS)
                                     + OFF_W'(r_cause[3:0]);
            SLOT_READ:    pick_off = OFF_W'(r_idx);
            default:      pick_off = '0;
        endcase
    end

    // Addend of the slot being written back
    always_comb begin
        unique case (r_pend_slot)
            SLOT_OCT_IN:  pend_add = r_oin;
            SLOT_OCT_OUT: pend_add = r_oout;
            default:      pend_add = 32'd1;
        endcase
    end

    // Memory port steering
    assign ram_re    = (r_state == S_RUN) && (r_mask != '0);
    assign ram_raddr = r_base + AW'(pick_off);
    assign ram_we    = (r_state == S_CLEAR) || (r_pend_valid && (r_pend_slot != SLOT_READ));
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_pend_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : (ram_rdata + {32'd0, pend_add});

    ccsc_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Capture of an accepted word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= i_operation;
            r_bucket   <= i_bucket;
            r_access   <= i_access_type;
            r_kind     <= i_request_kind;
            r_cause    <= i_term_cause;
            r_has_unit <= i_has_unit;
            r_oin      <= i_octets_in;
            r_oout     <= i_octets_out;
            r_reason   <= i_report_reason;
            r_last     <= i_last_unit;
            r_idx      <= i_counter_index;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_aband      <= 1'b0;
            r_mask       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= ram_re;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_aband  <= n_aband;
                    r_mask   <= n_mask;
                    r_status <= n_status;
                    r_wphase <= 1'b0;
                    r_bidx   <= BW'(r_bucket);
                    if (!n_needs_ram) begin
                        r_state <= S_OUT;
                    end else if (bucket_ok) begin
                        r_state <= S_ADDR;
                    end else begin
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (!r_wphase) begin
                        r_quot   <= BKT_W'(wrap_prod >> WRAP_SHIFT);
                        r_wphase <= 1'b1;
                    end else begin
                        r_bidx  <= BW'(wrap_rem);
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_base  <= (AW'(r_bidx) * AW'(ACCESS_KINDS) + AW'(r_access)) * AW'(CPS);
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_mask != '0) begin
                        r_mask[pick] <= 1'b0;
                    end else if (!r_pend_valid) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Read-back path: remember issue, capture returned counter
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_pend_slot <= pick;
            r_pend_addr <= ram_raddr;
        end
        if (r_state == S_DEC) begin
            r_value <= '0;
        end else if (r_pend_valid && (r_pend_slot == SLOT_READ)) begin
            r_value <= ram_rdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out_status <= r_status;
            r_out_value  <= r_value;
        end
    end

    // Checks
    `CCSC_CHECK(a_no_accept_in_clear, r_state == S_CLEAR, o_in_stall)
    `CCSC_CHECK(a_rw_distinct, ram_we && ram_re, ram_waddr != ram_raddr)
    `CCSC_CHECK(a_pend_in_run, r_pend_valid, r_state == S_RUN)
    `CCSC_CHECK_NEXT(a_run_drains, (r_state == S_RUN) && (r_mask == '0) && !r_pend_valid, r_state == S_OUT)

endmodule
